@@ rtl/paz_pkg.sv @@
// ----------------------------------------------------------------------------
// paz_pkg
// Shared widths, reset values and register codes of the pressure
// auto-zero and gain block.
// ----------------------------------------------------------------------------
package paz_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int GAIN_FULL_SCALE = 1024;

  localparam int DEV_BITS  = SAMPLE_BITS + 1;
  localparam int GAIN_BITS = $clog2(GAIN_FULL_SCALE + 1);

  // register field widths
  localparam int DRIFT_BITS    = 24;
  localparam int SHIFT_BITS    = 5;
  localparam int OFFSET_BITS   = 9;
  localparam int FACTOR_BITS   = 11;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [DRIFT_BITS-1:0]  DRIFT_LIMIT_RST  = DRIFT_BITS'(40960);
  localparam logic [SHIFT_BITS-1:0]  GAIN_SHIFT_RST   = SHIFT_BITS'(4);
  localparam logic [OFFSET_BITS-1:0] CURVE_OFFSET_RST = OFFSET_BITS'(64);
  localparam logic                   FIXED_MODE_RST   = 1'b0;
  localparam logic [FACTOR_BITS-1:0] FIXED_FACTOR_RST = FACTOR_BITS'(1024);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRIFT_LIMIT  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_SHIFT   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_OFFSET = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED_MODE   = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED_FACTOR = CFG_IDX_BITS'(4);

  // serial compare/subtract
  localparam int SMP_CNT_BITS = $clog2(SAMPLE_BITS);

  // serial x6 then /5 scaler
  localparam int MUL_BITS       = SAMPLE_BITS + 3;
  localparam int MUL_CNT_BITS   = $clog2(MUL_BITS);
  localparam int SCALE_DIV      = 5;
  localparam int SCALE_REM_BITS = $clog2(SCALE_DIV);

  // gain curve divider
  localparam int NUM_BITS     = 2 * GAIN_BITS;
  localparam int NUM_CNT_BITS = $clog2(NUM_BITS);
  localparam int CMP_BITS     = (DEV_BITS > GAIN_BITS + 1) ? DEV_BITS : GAIN_BITS + 1;

  typedef struct packed {
    logic done;
    logic s_gt_b;
    logic drift_gt;
  } paz_diff_stat_t;

endpackage

@@ rtl/paz_if.sv @@
// ----------------------------------------------------------------------------
// paz_if
// Valid/ready channels: sensor items in, result items out.
// ----------------------------------------------------------------------------
interface paz_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [paz_pkg::SAMPLE_BITS-1:0] sample;
  logic                            force_req;
  logic                            key_held;

  modport source (output valid, func, sample, force_req, key_held, input ready);
  modport sink   (input valid, func, sample, force_req, key_held, output ready);
endinterface

interface paz_out_if;
  logic                          valid;
  logic                          ready;
  logic [paz_pkg::DEV_BITS-1:0]  deviation;
  logic [paz_pkg::GAIN_BITS-1:0] gain;
  logic                          rezeroed;

  modport source (output valid, deviation, gain, rezeroed, input ready);
  modport sink   (input valid, deviation, gain, rezeroed, output ready);
endinterface

@@ rtl/paz_diff_ser.sv @@
// ----------------------------------------------------------------------------
// paz_diff_ser
// Bit-serial sample/baseline subtract in both directions, LSB first,
// with serial magnitude compare against the drift limit.
// ----------------------------------------------------------------------------
module paz_diff_ser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [paz_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic [paz_pkg::SAMPLE_BITS-1:0]   baseline,
  input  logic [paz_pkg::DRIFT_BITS-1:0]    drift_limit,
  output paz_pkg::paz_diff_stat_t           stat,
  output logic [paz_pkg::SAMPLE_BITS-1:0]   diff_up,
  output logic [paz_pkg::SAMPLE_BITS-1:0]   diff_dn
);

  logic [paz_pkg::SAMPLE_BITS-1:0]  s_sh, b_sh, up_sh, dn_sh;
  logic [paz_pkg::DRIFT_BITS-1:0]   l_sh;
  logic [paz_pkg::SMP_CNT_BITS-1:0] cnt;
  logic busy, done;
  logic bor_up, bor_dn, gt_up, gt_dn;
  logic sb, bb, lb, ub, db;

  assign sb = s_sh[0];
  assign bb = b_sh[0];
  assign lb = l_sh[0];
  assign ub = sb ^ bb ^ bor_up;
  assign db = bb ^ sb ^ bor_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        s_sh   <= sample;
        b_sh   <= baseline;
        l_sh   <= drift_limit;
        bor_up <= 1'b0;
        bor_dn <= 1'b0;
        gt_up  <= 1'b0;
        gt_dn  <= 1'b0;
      end else if (busy) begin
        s_sh   <= s_sh >> 1;
        b_sh   <= b_sh >> 1;
        l_sh   <= l_sh >> 1;
        up_sh  <= {ub, up_sh[paz_pkg::SAMPLE_BITS-1:1]};
        dn_sh  <= {db, dn_sh[paz_pkg::SAMPLE_BITS-1:1]};
        bor_up <= (~sb & bb) | (~(sb ^ bb) & bor_up);
        bor_dn <= (~bb & sb) | (~(bb ^ sb) & bor_dn);
        // LSB-first compare: a higher bit overrides
        gt_up  <= (ub & ~lb) | (gt_up & ~(ub ^ lb));
        gt_dn  <= (db & ~lb) | (gt_dn & ~(db ^ lb));
        cnt    <= cnt + 1'b1;
        if (cnt == paz_pkg::SMP_CNT_BITS'(paz_pkg::SAMPLE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // baseline - sample borrows out exactly when sample > baseline
  assign stat.done     = done;
  assign stat.s_gt_b   = bor_dn;
  assign stat.drift_gt = bor_dn ? gt_up : gt_dn;
  assign diff_up       = up_sh;
  assign diff_dn       = dn_sh;

endmodule

@@ rtl/paz_scale_ser.sv @@
// ----------------------------------------------------------------------------
// paz_scale_ser
// Bit-serial floor(d*6/5): shift-add x6 LSB first, then restoring
// divide by five MSB first in the same shift register.
// ----------------------------------------------------------------------------
module paz_scale_ser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [paz_pkg::SAMPLE_BITS-1:0]  d,
  output logic                             done,
  output logic [paz_pkg::DEV_BITS-1:0]     q
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} scale_state_t;

  scale_state_t                      state;
  logic [paz_pkg::SAMPLE_BITS-1:0]   d_sh;
  logic [paz_pkg::MUL_BITS-1:0]      p_sh;
  logic [paz_pkg::MUL_CNT_BITS-1:0]  cnt;
  logic [paz_pkg::SCALE_REM_BITS-1:0] rem;
  logic [paz_pkg::SCALE_REM_BITS:0]   r2;
  logic d1, d2, carry, pbit, ge;

  // bit k of 6d = bit k-1 of d + bit k-2 of d + carry
  assign pbit = d1 ^ d2 ^ carry;
  assign r2   = {rem, p_sh[paz_pkg::MUL_BITS-1]};
  assign ge   = r2 >= (paz_pkg::SCALE_REM_BITS + 1)'(paz_pkg::SCALE_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            d_sh  <= d;
            d1    <= 1'b0;
            d2    <= 1'b0;
            carry <= 1'b0;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          d_sh  <= d_sh >> 1;
          d1    <= d_sh[0];
          d2    <= d1;
          carry <= (d1 & d2) | (d1 & carry) | (d2 & carry);
          p_sh  <= {pbit, p_sh[paz_pkg::MUL_BITS-1:1]};
          cnt   <= cnt + 1'b1;
          if (cnt == paz_pkg::MUL_CNT_BITS'(paz_pkg::MUL_BITS - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          p_sh <= {p_sh[paz_pkg::MUL_BITS-2:0], ge};
          rem  <= ge ? paz_pkg::SCALE_REM_BITS'(r2 -
                       (paz_pkg::SCALE_REM_BITS + 1)'(paz_pkg::SCALE_DIV))
                     : r2[paz_pkg::SCALE_REM_BITS-1:0];
          cnt  <= cnt + 1'b1;
          if (cnt == paz_pkg::MUL_CNT_BITS'(paz_pkg::MUL_BITS - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q = p_sh[paz_pkg::DEV_BITS-1:0];

endmodule

@@ rtl/paz_gain_div.sv @@
// ----------------------------------------------------------------------------
// paz_gain_div
// Gain curve: shift, fixed-mode and dead-zone checks, then one quotient bit per cycle on the sloped middle.
// ----------------------------------------------------------------------------
module paz_gain_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [paz_pkg::DEV_BITS-1:0]      dev,
  input  logic [paz_pkg::SHIFT_BITS-1:0]    gain_shift,
  input  logic [paz_pkg::OFFSET_BITS-1:0]   curve_offset,
  input  logic                              fixed_mode,
  input  logic [paz_pkg::FACTOR_BITS-1:0]   fixed_factor,
  output logic                              done,
  output logic [paz_pkg::GAIN_BITS-1:0]     gain
);

  typedef enum logic [1:0] {G_IDLE, G_PREP, G_DIV} gain_state_t;

  localparam int SH_BITS = paz_pkg::SHIFT_BITS + 1;

  gain_state_t                        state;
  logic [paz_pkg::DEV_BITS-1:0]       t;
  logic [paz_pkg::NUM_BITS-1:0]       num_sh;
  logic [paz_pkg::GAIN_BITS-1:0]      den, rem;
  logic [paz_pkg::NUM_CNT_BITS-1:0]   cnt;
  logic [SH_BITS-1:0]                 sh_amt;
  logic [paz_pkg::CMP_BITS-1:0]       t_c, off_c, fs_c, ff_c, span_c, rel_c;
  logic [paz_pkg::GAIN_BITS-1:0]      fixed_gain;
  logic [paz_pkg::NUM_BITS-1:0]       prod;
  logic                               mid_ok;
  logic [paz_pkg::GAIN_BITS:0]        r2;
  logic                               ge;

  assign sh_amt = SH_BITS'(gain_shift) + SH_BITS'(2);

  assign t_c    = paz_pkg::CMP_BITS'(t);
  assign off_c  = paz_pkg::CMP_BITS'(curve_offset);
  assign fs_c   = paz_pkg::CMP_BITS'(paz_pkg::GAIN_FULL_SCALE);
  assign ff_c   = paz_pkg::CMP_BITS'(fixed_factor);
  assign span_c = fs_c - (off_c << 1);
  assign rel_c  = t_c - off_c;
  assign mid_ok = ((off_c << 1) < fs_c) && (t_c <= fs_c - off_c);
  assign prod   = paz_pkg::NUM_BITS'(rel_c[paz_pkg::GAIN_BITS-1:0]) *
                  paz_pkg::NUM_BITS'(paz_pkg::GAIN_FULL_SCALE);
  assign fixed_gain = (ff_c > fs_c) ? paz_pkg::GAIN_BITS'(paz_pkg::GAIN_FULL_SCALE)
                                    : ff_c[paz_pkg::GAIN_BITS-1:0];

  assign r2 = {rem, num_sh[paz_pkg::NUM_BITS-1]};
  assign ge = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) begin
            t     <= dev >> sh_amt;
            state <= G_PREP;
          end
        end
        G_PREP: begin
          priority if (fixed_mode) begin
            gain  <= fixed_gain;
            done  <= 1'b1;
            state <= G_IDLE;
          end else if (t_c < off_c) begin
            gain  <= '0;
            done  <= 1'b1;
            state <= G_IDLE;
          end else if (mid_ok) begin
            num_sh <= prod;
            den    <= span_c[paz_pkg::GAIN_BITS-1:0];
            rem    <= '0;
            cnt    <= '0;
            state  <= G_DIV;
          end else begin
            gain  <= paz_pkg::GAIN_BITS'(paz_pkg::GAIN_FULL_SCALE);
            done  <= 1'b1;
            state <= G_IDLE;
          end
        end
        G_DIV: begin
          num_sh <= {num_sh[paz_pkg::NUM_BITS-2:0], ge};
          rem    <= ge ? paz_pkg::GAIN_BITS'(r2 - {1'b0, den})
                       : r2[paz_pkg::GAIN_BITS-1:0];
          cnt    <= cnt + 1'b1;
          if (cnt == paz_pkg::NUM_CNT_BITS'(paz_pkg::NUM_BITS - 1)) begin
            // quotient never exceeds full scale
            gain  <= {num_sh[paz_pkg::GAIN_BITS-2:0], ge};
            done  <= 1'b1;
            state <= G_IDLE;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/pressure_auto_zero_gain.sv @@
// ----------------------------------------------------------------------------
// pressure_auto_zero_gain
// Pressure baseline tracking with auto-zero and a gain curve, bit-serial.
// ----------------------------------------------------------------------------
// One item is in flight at a time. sensor.ready is high whenever the
// sequencer is idle. A finished result parks in the output register, so the
// next item can enter while it waits. A zero request gives no result and
// leaves the sequencer idle. A sample goes through the bit-serial
// subtract/compare (start, one bit per cycle, handoff), then the gain curve,
// and is then loaded into the output register. Outside fixed mode, the gain
// divider runs when t lands on the sloped middle of the curve. The serial x6
// and /5 run first when the sample sits at or below the baseline and is not
// re-zeroed. The next item can be accepted the cycle after the result is
// loaded; a finished item first waits for a full output register to drain.
// The bit-serial units are the one-bit-per-cycle subtractor, the
// one-bit-per-cycle 6/5 scaler and the one-quotient-bit-per-cycle gain
// divider. Registers are to be written by the user on the plain cfg port
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pressure_auto_zero_gain (
  input  logic                                clk,
  input  logic                                rst,
  paz_in_if.sink                              sensor,
  paz_out_if.source                           result,
  input  logic                                cfg_we,
  input  logic [paz_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [paz_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIFF, ST_SCALE, ST_GAIN, ST_OUT} top_state_t;

  top_state_t state;

  // configuration
  logic [paz_pkg::DRIFT_BITS-1:0]  drift_limit;
  logic [paz_pkg::SHIFT_BITS-1:0]  gain_shift;
  logic [paz_pkg::OFFSET_BITS-1:0] curve_offset;
  logic                            fixed_mode;
  logic [paz_pkg::FACTOR_BITS-1:0] fixed_factor;

  // block state
  logic [paz_pkg::SAMPLE_BITS-1:0] baseline;
  logic zero_pending, force_pending;

  // per-item working regs
  logic [paz_pkg::SAMPLE_BITS-1:0] smp;
  logic [paz_pkg::DEV_BITS-1:0]    dev;
  logic                            rez;
  logic diff_start, scale_start, gain_start;

  // output register
  logic                          out_valid;
  logic [paz_pkg::DEV_BITS-1:0]  out_dev;
  logic [paz_pkg::GAIN_BITS-1:0] out_gain;
  logic                          out_rez;

  paz_pkg::paz_diff_stat_t         diff_stat;
  logic [paz_pkg::SAMPLE_BITS-1:0] diff_up, diff_dn;
  logic                            scale_done, gain_done;
  logic [paz_pkg::DEV_BITS-1:0]    scale_q;
  logic [paz_pkg::GAIN_BITS-1:0]   gain_val;
  logic                            in_take, rez_now, out_load;

  assign sensor.ready = (state == ST_IDLE);
  assign in_take      = sensor.valid && sensor.ready;
  // re-zero when armed and drifted far enough, or when forced
  assign rez_now      = zero_pending && (diff_stat.drift_gt || force_pending);
  // output register takes the new item when free or emptying this cycle
  assign out_load     = (state == ST_OUT) && (!out_valid || result.ready);

  // config writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_limit  <= paz_pkg::DRIFT_LIMIT_RST;
      gain_shift   <= paz_pkg::GAIN_SHIFT_RST;
      curve_offset <= paz_pkg::CURVE_OFFSET_RST;
      fixed_mode   <= paz_pkg::FIXED_MODE_RST;
      fixed_factor <= paz_pkg::FIXED_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        paz_pkg::CFG_DRIFT_LIMIT:  drift_limit  <= cfg_data[paz_pkg::DRIFT_BITS-1:0];
        paz_pkg::CFG_GAIN_SHIFT:   gain_shift   <= cfg_data[paz_pkg::SHIFT_BITS-1:0];
        paz_pkg::CFG_CURVE_OFFSET: curve_offset <= cfg_data[paz_pkg::OFFSET_BITS-1:0];
        paz_pkg::CFG_FIXED_MODE:   fixed_mode   <= cfg_data[0];
        paz_pkg::CFG_FIXED_FACTOR: fixed_factor <= cfg_data[paz_pkg::FACTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      baseline      <= '0;
      zero_pending  <= 1'b0;
      force_pending <= 1'b0;
      diff_start    <= 1'b0;
      scale_start   <= 1'b0;
      gain_start    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      diff_start  <= 1'b0;
      scale_start <= 1'b0;
      gain_start  <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (sensor.func) begin
              // zero request; a held key masks it, a new one overwrites force
              if (!sensor.key_held) begin
                zero_pending  <= 1'b1;
                force_pending <= sensor.force_req;
              end
            end else begin
              smp        <= sensor.sample;
              diff_start <= 1'b1;
              state      <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          if (diff_stat.done) begin
            zero_pending  <= 1'b0;
            force_pending <= 1'b0;
            rez           <= rez_now;
            priority if (rez_now) begin
              baseline   <= smp;
              dev        <= '0;
              gain_start <= 1'b1;
              state      <= ST_GAIN;
            end else if (diff_stat.s_gt_b) begin
              dev        <= paz_pkg::DEV_BITS'(diff_up);
              gain_start <= 1'b1;
              state      <= ST_GAIN;
            end else begin
              // at or below baseline: scale by 6/5
              scale_start <= 1'b1;
              state       <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          if (scale_done) begin
            dev        <= scale_q;
            gain_start <= 1'b1;
            state      <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          // gain_val holds until the next gain start
          if (gain_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (out_load) begin
            out_dev  <= dev;
            out_gain <= gain_val;
            out_rez  <= rez;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid     = out_valid;
  assign result.deviation = out_dev;
  assign result.gain      = out_gain;
  assign result.rezeroed  = out_rez;

  paz_diff_ser u_diff (
    .clk         (clk),
    .rst         (rst),
    .start       (diff_start),
    .sample      (smp),
    .baseline    (baseline),
    .drift_limit (drift_limit),
    .stat        (diff_stat),
    .diff_up     (diff_up),
    .diff_dn     (diff_dn)
  );

  paz_scale_ser u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .d     (diff_dn),
    .done  (scale_done),
    .q     (scale_q)
  );

  paz_gain_div u_gain (
    .clk          (clk),
    .rst          (rst),
    .start        (gain_start),
    .dev          (dev),
    .gain_shift   (gain_shift),
    .curve_offset (curve_offset),
    .fixed_mode   (fixed_mode),
    .fixed_factor (fixed_factor),
    .done         (gain_done),
    .gain         (gain_val)
  );

endmodule
